[design/rtu_pkg.sv]
// Shared types, constants and the CRC-16 byte update of the RTU frame receiver.
`default_nettype none

package rtu_pkg;

    localparam int MAX_FRAME_BYTES     = 256;
    localparam int FIXED_REQUEST_BYTES = 8;
    localparam int COUNT_W             = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] CODE_WRITE_COILS = 8'h0F;
    localparam logic [7:0] CODE_WRITE_REGS  = 8'h10;

    localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
    localparam logic [1:0] STATUS_GOOD       = 2'd1;
    localparam logic [1:0] STATUS_BAD        = 2'd2;

    localparam logic FRAME_KIND_REQUEST  = 1'b0;
    localparam logic FRAME_KIND_RESPONSE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [15:0]        crc;
        logic [7:0]         tail_old;
        logic [7:0]         tail_new;
        logic [7:0]         address_byte;
        logic [7:0]         code_byte;
        logic [7:0]         count_byte;
    } frame_state_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               overrun;
        logic [7:0]         unit_address;
        logic [7:0]         function_code;
        logic [COUNT_W-1:0] frame_length;
        logic [15:0]        received_crc;
        logic [15:0]        computed_crc;
    } result_t;

    localparam frame_state_t FRAME_CLEAR = '{
        byte_count:   '0,
        crc:          CRC_INIT,
        tail_old:     8'h00,
        tail_new:     8'h00,
        address_byte: 8'h00,
        code_byte:    8'h00,
        count_byte:   8'h00
    };

    // Reflected CRC-16 update by one byte, eight shift steps unrolled.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, byte_in};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[design/rtu_input_stage.sv]
// Input register of the RTU frame receiver: holds one accepted word until it is processed.
`default_nettype none

module rtu_input_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             frame_start,
    output logic                  item_valid,
    input  wire logic             item_take,
    output rtu_pkg::in_item_t     item
);
    import rtu_pkg::*;

    logic     item_valid_reg;
    logic     item_valid_next;
    in_item_t item_reg;

    assign in_ready        = !item_valid_reg || item_take;
    assign item_valid_next = (in_valid && in_ready) || (item_valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= '{data_byte: data_byte, frame_start: frame_start};
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[design/rtu_frame_step.sv]
// Next frame state and status for one received byte.
`default_nettype none

module rtu_frame_step (
    input  wire rtu_pkg::frame_state_t state_cur,
    input  wire rtu_pkg::in_item_t     item,
    input  wire logic                  frame_kind,
    output rtu_pkg::frame_state_t      state_next,
    output rtu_pkg::result_t           result
);
    import rtu_pkg::*;

    frame_state_t base;
    frame_state_t upd;
    logic         full;
    logic         counted;
    logic         crc_match;
    logic [15:0]  wire_crc;
    logic [15:0]  swapped_crc;
    logic [COUNT_W:0] needed_len;
    logic [1:0]   status;

    always_comb
    begin
        base = item.frame_start ? FRAME_CLEAR : state_cur;
        full = base.byte_count >= COUNT_W'(MAX_FRAME_BYTES);
        upd  = base;
        if (!full)
        begin
            // The older tail byte leaves the CRC candidate and joins the checked data.
            if (base.byte_count >= COUNT_W'(2))
                upd.crc = crc_fold(base.crc, base.tail_old);
            upd.tail_old = base.tail_new;
            upd.tail_new = item.data_byte;
            if (base.byte_count == COUNT_W'(0))
                upd.address_byte = item.data_byte;
            else if (base.byte_count == COUNT_W'(1))
                upd.code_byte = item.data_byte;
            else if (base.byte_count == COUNT_W'(2))
                upd.count_byte = item.data_byte;
            upd.byte_count = base.byte_count + COUNT_W'(1);
        end
        state_next = upd;
    end

    assign wire_crc    = {upd.tail_old, upd.tail_new};
    assign swapped_crc = {upd.crc[7:0], upd.crc[15:8]};
    assign crc_match   = (wire_crc == swapped_crc);
    assign counted     = (frame_kind == FRAME_KIND_RESPONSE) ||
                         (upd.code_byte == CODE_WRITE_COILS) ||
                         (upd.code_byte == CODE_WRITE_REGS);
    assign needed_len  = {{(COUNT_W + 1 - 8){1'b0}}, upd.count_byte} + (COUNT_W + 1)'(3);

    always_comb
    begin
        if (upd.byte_count < COUNT_W'(3))
            status = STATUS_INCOMPLETE;
        else if (counted)
        begin
            if ({1'b0, upd.byte_count} < needed_len)
                status = STATUS_INCOMPLETE;
            else
                status = crc_match ? STATUS_GOOD : STATUS_BAD;
        end
        else if (upd.byte_count > COUNT_W'(FIXED_REQUEST_BYTES))
            status = STATUS_BAD;
        else if (upd.byte_count == COUNT_W'(FIXED_REQUEST_BYTES))
            status = crc_match ? STATUS_GOOD : STATUS_BAD;
        else
            status = STATUS_INCOMPLETE;
    end

    assign result = '{
        status:        status,
        overrun:       full,
        unit_address:  upd.address_byte,
        function_code: upd.code_byte,
        frame_length:  upd.byte_count,
        received_crc:  wire_crc,
        computed_crc:  swapped_crc
    };

endmodule

`default_nettype wire

[design/rtu_frame_receiver_crc16_core.sv]
// Modbus RTU frame receiver with running CRC-16 check: top level.
//
// Bytes enter on the in channel (in_valid/in_ready, data_byte, frame_start) in line
// order; frame_start clears the frame so that its word becomes byte 0. Every input
// word yields exactly one result word on the out channel (out_valid/out_ready):
// status, overrun flag, header bytes, length, wire CRC and computed CRC.
// The cfg channel (cfg_valid/cfg_ready, cfg_data) writes frame_kind: 0 checks frames
// as requests, 1 as responses. It is always ready; it is written while idle by the user, the block does not enforce it.
// A word enters the input register, then passes through the frame update into the result
// register. Throughput is one word per cycle unless out_ready stalls the result; the
// unrolled eight-step CRC byte update between those registers sets the cycle.
// When the receiver holds out_ready low the result register keeps its word, the
// input register still takes one more word, and in_ready falls after that.
// Reset empties both registers, clears the frame (CRC 0xFFFF) and sets request mode.
`default_nettype none

module rtu_frame_receiver_crc16_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        frame_start,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       status,
    output logic                             overrun,
    output logic [7:0]                       unit_address,
    output logic [7:0]                       function_code,
    output logic [rtu_pkg::COUNT_W-1:0]      frame_length,
    output logic [15:0]                      received_crc,
    output logic [15:0]                      computed_crc
);
    import rtu_pkg::*;

    logic         item_valid;
    logic         item_take;
    in_item_t     item;
    frame_state_t state_reg;
    frame_state_t state_next;
    result_t      step_result;
    result_t      result_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         frame_kind_reg;

    rtu_input_stage u_input_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .item        (item)
    );

    rtu_frame_step u_frame_step (
        .state_cur  (state_reg),
        .item       (item),
        .frame_kind (frame_kind_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    assign cfg_ready      = 1'b1;
    assign item_take      = item_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = item_take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FRAME_CLEAR;
            out_valid_reg  <= 1'b0;
            frame_kind_reg <= FRAME_KIND_REQUEST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                frame_kind_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            result_reg <= step_result;
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign overrun       = result_reg.overrun;
    assign unit_address  = result_reg.unit_address;
    assign function_code = result_reg.function_code;
    assign frame_length  = result_reg.frame_length;
    assign received_crc  = result_reg.received_crc;
    assign computed_crc  = result_reg.computed_crc;

endmodule

`default_nettype wire

[design/rtu_checker.sv]
// Port-level assertions for the RTU frame receiver, bound to the top level.
`default_nettype none

module rtu_checker (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [1:0]             status,
    input  wire logic                   overrun,
    input  wire logic [rtu_pkg::COUNT_W-1:0] frame_length,
    input  wire logic [15:0]            received_crc,
    input  wire logic [15:0]            computed_crc
);
    import rtu_pkg::*;

    // A stalled result word must not change under the receiver.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_length))
        else $error("result word changed while stalled");

    // A dropped byte only happens on a full frame.
    a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overrun |-> frame_length == COUNT_W'(MAX_FRAME_BYTES))
        else $error("overrun reported on a frame that is not full");

    // Fewer than three bytes can never be a complete frame.
    a_short_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_length < COUNT_W'(3) |-> status == STATUS_INCOMPLETE)
        else $error("short frame reported as complete");

    // A good verdict requires the wire CRC to match the computed one.
    a_good_crc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_GOOD |-> received_crc == computed_crc)
        else $error("good status with mismatching CRC");

endmodule

bind rtu_frame_receiver_crc16_core rtu_checker u_rtu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .overrun      (overrun),
    .frame_length (frame_length),
    .received_crc (received_crc),
    .computed_crc (computed_crc)
);

`default_nettype wire

[tb/sv/tb_rtu_frame_receiver_crc16_core.sv]
// Self-checking testbench for the RTU frame receiver core with its own frame and CRC predictor.
`timescale 1ns / 100ps

module tb_rtu_frame_receiver_crc16_core;
    import rtu_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 160;

    typedef struct {
        bit         cfg_write;
        logic [7:0] data;
        logic       start;
        int         reps;
        bit         typed;
        logic [1:0] status;
        logic       overrun;
        int         length;
    } stim_row_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic                cfg_data    = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [7:0]          data_byte   = 8'h00;
    logic                frame_start = 1'b0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [1:0]          status;
    logic                overrun;
    logic [7:0]          unit_address;
    logic [7:0]          function_code;
    logic [COUNT_W-1:0]  frame_length;
    logic [15:0]         received_crc;
    logic [15:0]         computed_crc;

    // Predictor copy of the frame state and the mode register.
    logic                kind_q;
    logic [COUNT_W-1:0]  held_bytes;
    logic [15:0]         crc_acc;
    logic [7:0]          tail_old;
    logic [7:0]          tail_new;
    logic [7:0]          addr_q;
    logic [7:0]          code_q;
    logic [7:0]          count_q;

    result_t             frame_reports_q[$];
    stim_row_t           directed_rows[$];
    int                  errors     = 0;
    int                  words_sent = 0;
    int                  cycles     = 0;
    int                  send_idle  = 0;
    int                  recv_idle  = 0;

    rtu_frame_receiver_crc16_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .overrun       (overrun),
        .unit_address  (unit_address),
        .function_code (function_code),
        .frame_length  (frame_length),
        .received_crc  (received_crc),
        .computed_crc  (computed_crc)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // CRC-16/MODBUS fed one bit at a time, least significant bit first.
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void clear_frame_model();
        held_bytes = '0;
        crc_acc    = CRC_INIT;
        tail_old   = 8'h00;
        tail_new   = 8'h00;
        addr_q     = 8'h00;
        code_q     = 8'h00;
        count_q    = 8'h00;
    endfunction

    function automatic result_t receive_byte(input logic [7:0] b, input logic s);
        result_t     r;
        logic [15:0] wire_word;
        logic [15:0] calc_word;
        logic [1:0]  verdict;
        if (s)
            clear_frame_model();
        r.overrun = (held_bytes >= MAX_FRAME_BYTES);
        if (!r.overrun)
        begin
            // The older tail byte leaves the CRC window before the tail shifts.
            if (held_bytes >= 2)
                crc_acc = crc16_step(crc_acc, tail_old);
            tail_old = tail_new;
            tail_new = b;
            case (held_bytes)
                0: addr_q = b;
                1: code_q = b;
                2: count_q = b;
                default: ;
            endcase
            held_bytes = held_bytes + 1'b1;
        end
        wire_word = {tail_old, tail_new};
        calc_word = {crc_acc[7:0], crc_acc[15:8]};
        verdict   = (wire_word == calc_word) ? STATUS_GOOD : STATUS_BAD;
        if (held_bytes < 3)
            r.status = STATUS_INCOMPLETE;
        else if (kind_q == FRAME_KIND_RESPONSE || code_q == CODE_WRITE_COILS
                 || code_q == CODE_WRITE_REGS)
            r.status = (int'(held_bytes) < int'(count_q) + 3) ? STATUS_INCOMPLETE : verdict;
        else if (held_bytes > FIXED_REQUEST_BYTES)
            r.status = STATUS_BAD;
        else if (held_bytes == FIXED_REQUEST_BYTES)
            r.status = verdict;
        else
            r.status = STATUS_INCOMPLETE;
        r.unit_address  = addr_q;
        r.function_code = code_q;
        r.frame_length  = held_bytes;
        r.received_crc  = wire_word;
        r.computed_crc  = calc_word;
        return r;
    endfunction

    function automatic void report_mismatch(input string field, input int unsigned want,
                                            input int unsigned got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endfunction

    function automatic void check_report(input result_t want, input result_t got);
        if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
        if (got.overrun !== want.overrun)
            report_mismatch("overrun", want.overrun, got.overrun);
        if (got.unit_address !== want.unit_address)
            report_mismatch("unit_address", want.unit_address, got.unit_address);
        if (got.function_code !== want.function_code)
            report_mismatch("function_code", want.function_code, got.function_code);
        if (got.frame_length !== want.frame_length)
            report_mismatch("frame_length", want.frame_length, got.frame_length);
        if (got.received_crc !== want.received_crc)
            report_mismatch("received_crc", want.received_crc, got.received_crc);
        if (got.computed_crc !== want.computed_crc)
            report_mismatch("computed_crc", want.computed_crc, got.computed_crc);
    endfunction

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {status, overrun, unit_address, function_code, frame_length,
                       received_crc, computed_crc};
                if (frame_reports_q.size() == 0)
                begin
                    $display("%0t: result word with nothing outstanding, expected none, actual %0h",
                             $time, got);
                    errors++;
                end
                else
                    check_report(frame_reports_q.pop_front(), got);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic s);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frame_reports_q.push_back(receive_byte(b, s));
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (frame_reports_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_kind(input logic kind);
        cfg_valid <= 1'b1;
        cfg_data  <= kind;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        kind_q = kind;
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with a correct CRC; some corrupted, cut short,
    // padded, or replaced by a burst of line noise.
    task automatic send_random_frame();
        logic [7:0]  body[$];
        logic [7:0]  code;
        logic [15:0] acc;
        int          pick;
        int          n;
        int          idx;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 12))
                send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            return;
        end
        body.push_back(8'($urandom_range(0, 255)));
        if (kind_q == FRAME_KIND_REQUEST && pick < 55)
        begin
            do
                code = 8'($urandom_range(0, 255));
            while (code == CODE_WRITE_COILS || code == CODE_WRITE_REGS);
            body.push_back(code);
            repeat (4)
                body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (pick < 75)
                code = $urandom_range(0, 1) ? CODE_WRITE_COILS : CODE_WRITE_REGS;
            else
                code = 8'($urandom_range(0, 255));
            // A rare long frame runs up to and past the frame limit.
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 20);
            body.push_back(code);
            body.push_back(8'(n));
            while (body.size() < n + 1)
                body.push_back(8'($urandom_range(0, 255)));
        end
        acc = CRC_INIT;
        foreach (body[i])
            acc = crc16_step(acc, body[i]);
        body.push_back(acc[7:0]);
        body.push_back(acc[15:8]);
        if ($urandom_range(0, 99) < 12)
        begin
            idx       = $urandom_range(0, body.size() - 1);
            body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, body.size() - 1))
                void'(body.pop_back());
        else if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 4))
                body.push_back(8'($urandom_range(0, 255)));
        foreach (body[i])
            send_word(body[i], i == 0);
    endtask

    function automatic void row(input bit cfg_write, input logic [7:0] data, input logic start,
                                input int reps, input bit typed, input logic [1:0] st,
                                input logic ovr, input int len);
        stim_row_t r;
        r.cfg_write = cfg_write;
        r.data      = data;
        r.start     = start;
        r.reps      = reps;
        r.typed     = typed;
        r.status    = st;
        r.overrun   = ovr;
        r.length    = len;
        directed_rows.push_back(r);
    endfunction

    initial
    begin : stimulus
        result_t typed_word;
        int      base;
        kind_q = FRAME_KIND_REQUEST;
        clear_frame_model();

        // Byte straight after reset, then a good eight-byte read request and one byte too many.
        row(0, 8'hFF, 0, 1, 1, STATUS_INCOMPLETE, 0, 1);
        row(0, 8'h01, 1, 1, 1, STATUS_INCOMPLETE, 0, 1);
        row(0, 8'h03, 0, 1, 1, STATUS_INCOMPLETE, 0, 2);
        row(0, 8'h00, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h00, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h00, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h0A, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'hC5, 0, 1, 1, STATUS_INCOMPLETE, 0, 7);
        row(0, 8'hCD, 0, 1, 1, STATUS_GOOD, 0, 8);
        row(0, 8'h00, 0, 1, 1, STATUS_BAD, 0, 9);
        // Response mode: completion follows the count field.
        row(1, FRAME_KIND_RESPONSE, 0, 0, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h01, 1, 1, 1, STATUS_INCOMPLETE, 0, 1);
        row(0, 8'h03, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h02, 0, 1, 1, STATUS_INCOMPLETE, 0, 3);
        row(0, 8'h00, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h0A, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        // Write-multiple request with a zero count completes at three bytes.
        row(1, FRAME_KIND_REQUEST, 0, 0, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h11, 1, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, CODE_WRITE_REGS, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h00, 0, 1, 0, STATUS_INCOMPLETE, 0, 0);
        // Fill the frame, overrun it, then restart on the full frame.
        row(0, 8'h00, 1, 1, 1, STATUS_INCOMPLETE, 0, 1);
        row(0, 8'hFF, 0, MAX_FRAME_BYTES - 1, 0, STATUS_INCOMPLETE, 0, 0);
        row(0, 8'h5A, 0, 1, 1, STATUS_BAD, 1, MAX_FRAME_BYTES);
        row(0, 8'hA5, 1, 1, 1, STATUS_INCOMPLETE, 0, 1);

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 31;
        recv_idle = 53;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg_write)
            begin
                drain_results();
                write_kind(directed_rows[i].data[0]);
            end
            else
            begin
                for (int k = 0; k < directed_rows[i].reps; k++)
                    send_word(directed_rows[i].data, directed_rows[i].start && k == 0);
                if (directed_rows[i].typed)
                begin
                    typed_word              = frame_reports_q.pop_back();
                    typed_word.status       = directed_rows[i].status;
                    typed_word.overrun      = directed_rows[i].overrun;
                    typed_word.frame_length = COUNT_W'(directed_rows[i].length);
                    frame_reports_q.push_back(typed_word);
                end
            end
        end

        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            case (p / 2)
                0:
                begin
                    send_idle = 31;
                    recv_idle = 53;
                end
                1:
                begin
                    send_idle = 53;
                    recv_idle = 31;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            write_kind(p[0] ^ (p / 2 == 2));
            base = words_sent;
            while (words_sent - base < PHASE_WORDS)
                send_random_frame();
        end

        drain_results();
        repeat (6)
            @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
